// ===== rtl/wavr_pkg.sv =====
// shared types and constants for the windowed average and rate core
package wavr_pkg;

    // channel mode codes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_RATE = 2'd1;
    localparam logic [1:0] MODE_AVG  = 2'd2;

    // result kind codes
    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_AVG  = 1'b1;

    // divider geometry: rate dividend magnitude up to 2^32 * 1e6, below 2^52
    localparam int NUM_W = 53;
    localparam int DEN_W = 49;
    localparam int DIV_CNT_W = 7;

    // scaling of a rate to per second
    localparam logic [19:0] US_PER_S = 20'd1000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ,
        ST_UPDATE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic read_ring;
        logic update;
        logic mul;
        logic div_start;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic chan_ok;
        logic emit;
        logic need_mul;
        logic div_done;
    } dp_status_t;

endpackage

// ===== rtl/wavr_divider.sv =====
// restoring divider, one quotient bit per cycle
module wavr_divider
    import wavr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    logic [NUM_W-1:0]     q_reg, q_next;
    logic [DEN_W:0]       rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;

    // one shift and subtract step
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/wavr_datapath.sv =====
// per channel state, sample ring, rate and average arithmetic
module wavr_datapath
    import wavr_pkg::*;
#(
    parameter int WINDOW_LIMIT = 15,
    parameter int CHANNELS     = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [15:0] channel_modes,
    input  logic [2:0]  channel,
    input  logic [31:0] sample_value,
    input  logic [7:0]  source_id,
    input  logic [47:0] time_us,
    output logic [2:0]  out_channel,
    output logic        result_kind,
    output logic [31:0] derived_value,
    output logic [7:0]  out_source_id,
    output logic [47:0] out_time_us
);

    localparam int DEPTH   = WINDOW_LIMIT + 1;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W   = 32 + FILL_W + 1;
    localparam int ADDR_W  = CH_W + SLOT_W;
    localparam int RING_N  = CHANNELS * DEPTH;

    // per channel state
    logic [FILL_W-1:0] fill_reg   [CHANNELS];
    logic [SLOT_W-1:0] slot_reg   [CHANNELS];
    logic [SUM_W-1:0]  sum_reg    [CHANNELS];
    logic [47:0]       newest_reg [CHANNELS];
    logic [47:0]       prev_reg   [CHANNELS];

    // sample ring memory
    logic [31:0] ring_mem [RING_N];
    logic [31:0] old_rd_reg, prev_rd_reg;

    // captured beat
    logic [2:0]        ch_reg;
    logic [CH_W-1:0]   ci;
    logic [31:0]       val_reg;
    logic [7:0]        src_reg;
    logic [47:0]       t_reg;
    logic [1:0]        mode_reg;
    logic [SLOT_W-1:0] cur_slot_reg, pslot_reg;
    logic [FILL_W-1:0] cur_fill_reg;

    // working values
    logic              neg_reg;
    logic              emit_reg;
    logic [32:0]       diff_mag_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quot;
    logic              div_done;

    // result registers
    logic [2:0]        out_channel_reg;
    logic              result_kind_reg;
    logic [31:0]       derived_value_reg;
    logic [7:0]        out_source_id_reg;
    logic [47:0]       out_time_us_reg;

    assign ci = CH_W'(ch_reg);

    // slot before the current one, with wrap
    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        slot_dec = (s == '0) ? SLOT_W'(DEPTH - 1) : s - 1'b1;
    endfunction

    // capture of the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel;
            val_reg  <= sample_value;
            src_reg  <= source_id;
            t_reg    <= time_us;
            mode_reg <= channel_modes[{channel, 1'b0} +: 2];
        end
    end

    // channel lookup and ring read addresses
    logic [ADDR_W-1:0] base_addr;
    assign base_addr = ADDR_W'(ci) * ADDR_W'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.read_ring)
        begin
            cur_slot_reg <= slot_reg[ci];
            pslot_reg    <= slot_dec(slot_reg[ci]);
            cur_fill_reg <= fill_reg[ci];
            old_rd_reg   <= ring_mem[base_addr + ADDR_W'(slot_reg[ci])];
            prev_rd_reg  <= ring_mem[base_addr + ADDR_W'(slot_dec(slot_reg[ci]))];
        end
        if (cmd.update)
        begin
            ring_mem[base_addr + ADDR_W'(cur_slot_reg)] <= val_reg;
        end
    end

    // update arithmetic
    logic              full;
    logic [FILL_W-1:0] fill_new;
    logic [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]  sum_abs;
    logic [48:0]       dt;
    logic [48:0]       dt_abs;
    logic [32:0]       diff;
    logic [32:0]       diff_abs;

    always_comb
    begin
        full     = (cur_fill_reg >= FILL_W'(DEPTH));
        fill_new = full ? FILL_W'(DEPTH) : cur_fill_reg + 1'b1;
        sum_new  = sum_reg[ci] + SUM_W'(signed'(val_reg))
                   - (full ? SUM_W'(signed'(old_rd_reg)) : '0);
        sum_abs  = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
        dt       = {1'b0, t_reg} - {1'b0, newest_reg[ci]};
        dt_abs   = dt[48] ? (~dt + 1'b1) : dt;
        diff     = {val_reg[31], val_reg} - {prev_rd_reg[31], prev_rd_reg};
        diff_abs = diff[32] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i]   <= '0;
                slot_reg[i]   <= '0;
                sum_reg[i]    <= '0;
                newest_reg[i] <= '0;
                prev_reg[i]   <= '0;
            end
            emit_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            fill_reg[ci]   <= fill_new;
            slot_reg[ci]   <= (cur_slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : cur_slot_reg + 1'b1;
            sum_reg[ci]    <= sum_new;
            prev_reg[ci]   <= newest_reg[ci];
            newest_reg[ci] <= t_reg;
            unique case (mode_reg)
                MODE_RATE: emit_reg <= (fill_new >= FILL_W'(2)) && (dt != '0);
                MODE_AVG:  emit_reg <= 1'b1;
                default:   emit_reg <= 1'b0;
            endcase
        end
    end

    // operand setup, then, for a rate, the scale by one million in its own step
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (mode_reg == MODE_RATE)
            begin
                neg_reg      <= diff[32] ^ dt[48];
                diff_mag_reg <= diff_abs;
                den_reg      <= dt_abs;
                num_reg      <= '0;
            end
            else
            begin
                neg_reg      <= sum_new[SUM_W-1];
                diff_mag_reg <= '0;
                den_reg      <= DEN_W'(fill_new);
                num_reg      <= NUM_W'(sum_abs);
            end
        end
        else if (cmd.mul)
        begin
            num_reg <= NUM_W'(diff_mag_reg) * NUM_W'(US_PER_S);
        end
    end

    wavr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // sign and saturation
    logic [31:0] res;
    always_comb
    begin
        if (neg_reg)
            res = (quot >= NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (~quot[31:0] + 1'b1);
        else
            res = (quot > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_channel_reg   <= ch_reg;
            result_kind_reg   <= (mode_reg == MODE_AVG) ? KIND_AVG : KIND_RATE;
            derived_value_reg <= res;
            out_source_id_reg <= src_reg;
            out_time_us_reg   <= t_reg;
        end
    end

    assign out_channel   = out_channel_reg;
    assign result_kind   = result_kind_reg;
    assign derived_value = derived_value_reg;
    assign out_source_id = out_source_id_reg;
    assign out_time_us   = out_time_us_reg;

    assign status.chan_ok  = (32'(ch_reg) < CHANNELS);
    assign status.emit     = emit_reg;
    assign status.need_mul = (mode_reg == MODE_RATE);
    assign status.div_done = div_done;

endmodule

// ===== rtl/wavr_ctrl.sv =====
// sequencing controller for one beat at a time
module wavr_ctrl
    import wavr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (valid) state_next = ST_LOOKUP;
            ST_LOOKUP:    state_next = status.chan_ok ? ST_READ : ST_IDLE;
            ST_READ:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_MUL;
            ST_MUL:       state_next = status.emit ? ST_DIV_START : ST_IDLE;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (status.div_done) state_next = out_free ? ST_IDLE : ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        ready         = (state_reg == ST_IDLE);
        out_valid     = out_valid_reg;
        cmd.capture   = (state_reg == ST_IDLE) && valid;
        cmd.read_ring = (state_reg == ST_LOOKUP);
        cmd.update    = (state_reg == ST_UPDATE);
        cmd.mul       = (state_reg == ST_MUL) && status.need_mul;
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.load_out  = (((state_reg == ST_DIV_WAIT) && status.div_done)
                         || (state_reg == ST_OUT)) && out_free;
    end

    // result valid flag
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

endmodule

// ===== rtl/windowed_average_and_rate_core.sv =====
// top level of the windowed average and rate core
//  channel  | signals                                   | dir
//  sample   | valid, ready, channel, sample_value, ...  | in
//  result   | out_valid, out_ready, out_channel, ...    | out
//  config   | cfg_we, cfg_data                          | in
// one beat at a time: a new beat is taken only once the last one is through
// a beat with a result also passes through the 53-step restoring divider
// reset clears all channel state at once; the ring needs no clearing
// ready is low while a beat is in work; a result waits in the output register
// a new result stalls only while the previous one has not been taken
module windowed_average_and_rate_core
    import wavr_pkg::*;
#(
    parameter int WINDOW_LIMIT = 15,
    parameter int CHANNELS     = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        valid,
    output logic        ready,
    input  logic [2:0]  channel,
    input  logic [31:0] sample_value,
    input  logic [7:0]  source_id,
    input  logic [47:0] time_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_channel,
    output logic        result_kind,
    output logic [31:0] derived_value,
    output logic [7:0]  out_source_id,
    output logic [47:0] out_time_us
);

    logic [15:0] modes_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modes_reg <= '0;
        else if (cfg_we)
            modes_reg <= cfg_data;
    end

    wavr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wavr_datapath #(
        .WINDOW_LIMIT (WINDOW_LIMIT),
        .CHANNELS     (CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .channel_modes (modes_reg),
        .channel       (channel),
        .sample_value  (sample_value),
        .source_id     (source_id),
        .time_us       (time_us),
        .out_channel   (out_channel),
        .result_kind   (result_kind),
        .derived_value (derived_value),
        .out_source_id (out_source_id),
        .out_time_us   (out_time_us)
    );

`ifndef SYNTHESIS
    // result register loaded only when empty or being drained
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid || out_ready)
        else $error("result overwritten while pending");

    // a result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(derived_value))
        else $error("result dropped");

    // divider finishes only while being waited on
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> !ready)
        else $error("divider done while idle");
`endif

endmodule

// ===== verif/tb_top.sv =====
// testbench for the windowed average and rate core: scoreboard class and stimulus
`timescale 1ns / 100ps

module tb_top;
    import wavr_pkg::*;

    localparam int DEPTH = 16;
    localparam int NCH = 8;
    localparam longint CYCLE_LIMIT = 600000;

    // window mean and rate predictor with result store
    class window_rate_scoreboard;
        logic [15:0] modes;
        logic [31:0] ring [NCH][DEPTH];
        int unsigned fill [NCH];
        int unsigned wslot [NCH];
        longint wsum [NCH];
        logic [47:0] t_new [NCH];
        logic [47:0] t_prev [NCH];
        logic [91:0] expected_q [$];
        int errors;
        int results_seen;

        function new();
            modes = '0;
            errors = 0;
            results_seen = 0;
            for (int c = 0; c < NCH; c++)
            begin
                fill[c] = 0; wslot[c] = 0; wsum[c] = 0; t_new[c] = '0; t_prev[c] = '0;
            end
        endfunction

        // truncating divide, saturated to 32 bits
        function logic [31:0] quot_sat(logic signed [127:0] n, logic signed [127:0] d);
            logic signed [127:0] q;
            q = n / d;
            if (q > 128'sd2147483647) return 32'h7fffffff;
            if (q < -128'sd2147483648) return 32'h80000000;
            return q[31:0];
        endfunction

        // update channel state for an accepted sample beat and queue any result
        function void note_sample(logic [2:0] ch, logic [31:0] v, logic [7:0] src,
                                  logic [47:0] t);
            int unsigned slot;
            logic [1:0] m;
            logic signed [127:0] diff, dt;
            logic [31:0] res;
            slot = wslot[ch];
            if (fill[ch] >= DEPTH)
                wsum[ch] -= longint'($signed(ring[ch][slot]));
            else
                fill[ch]++;
            ring[ch][slot] = v;
            wsum[ch] += longint'($signed(v));
            wslot[ch] = (slot + 1) % DEPTH;
            t_prev[ch] = t_new[ch];
            t_new[ch] = t;
            m = modes[2*ch +: 2];
            if (m == MODE_RATE)
            begin
                if (fill[ch] < 2) return;
                dt = $signed({80'd0, t}) - $signed({80'd0, t_prev[ch]});
                if (dt == 0) return;
                diff = 128'($signed(v)) - 128'($signed(ring[ch][(slot + DEPTH - 1) % DEPTH]));
                res = quot_sat(diff * 1000000, dt);
                expected_q.push_back({ch, KIND_RATE, res, src, t});
            end
            else if (m == MODE_AVG)
            begin
                res = quot_sat(128'(wsum[ch]), 128'(fill[ch]));
                expected_q.push_back({ch, KIND_AVG, res, src, t});
            end
        endfunction

        // compare a result beat with the oldest expectation
        function void check_result(logic [2:0] ch, logic k, logic [31:0] v,
                                   logic [7:0] src, logic [47:0] t);
            logic [91:0] e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat on channel %0d", ch);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (e[91:89] != ch)
            begin
                $error("out_channel exp %0d got %0d", e[91:89], ch);
                errors++;
            end
            if (e[88] != k)
            begin
                $error("result_kind exp %0d got %0d", e[88], k);
                errors++;
            end
            if (e[87:56] != v)
            begin
                $error("derived_value exp %0d got %0d", $signed(e[87:56]), $signed(v));
                errors++;
            end
            if (e[55:48] != src)
            begin
                $error("out_source_id exp %0d got %0d", e[55:48], src);
                errors++;
            end
            if (e[47:0] != t)
            begin
                $error("out_time_us exp %0d got %0d", e[47:0], t);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic [31:0] sample_value;
    logic [7:0]  source_id;
    logic [47:0] time_us;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  out_channel;
    logic        result_kind;
    logic [31:0] derived_value;
    logic [7:0]  out_source_id;
    logic [47:0] out_time_us;

    window_rate_scoreboard sb;
    longint cycles;
    int samples_sent;
    logic [47:0] chan_time [NCH];
    bit drain_stall;

    windowed_average_and_rate_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .valid(valid), .ready(ready), .channel(channel), .sample_value(sample_value),
        .source_id(source_id), .time_us(time_us), .out_valid(out_valid),
        .out_ready(out_ready), .out_channel(out_channel), .result_kind(result_kind),
        .derived_value(derived_value), .out_source_id(out_source_id),
        .out_time_us(out_time_us)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side: random stalls, check at rising edge
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = drain_stall ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_channel, result_kind, derived_value, out_source_id,
                            out_time_us);
            @(negedge clk);
        end
    end

    // one sample beat with a random lead-in gap
    task automatic send_sample(logic [2:0] ch, logic [31:0] v, logic [7:0] src,
                               logic [47:0] t);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        valid <= 1'b1;
        channel <= ch;
        sample_value <= v;
        source_id <= src;
        time_us <= t;
        do @(posedge clk); while (!ready);
        sb.note_sample(ch, v, src, t);
        samples_sent++;
        chan_time[ch] = t;
        @(negedge clk);
    endtask

    // sample with a random time step from the channel's last one
    task automatic send_next(logic [2:0] ch, logic [31:0] v);
        logic [47:0] step;
        case ($urandom_range(0, 9))
            0: step = 48'd0;
            1: step = -48'($urandom_range(1, 1000));
            2: step = 48'd1;
            3: step = 48'({$urandom, $urandom});
            default: step = 48'($urandom_range(1, 2000000));
        endcase
        send_sample(ch, v, 8'($urandom), chan_time[ch] + step);
    endtask

    // wait until idle, then write the mode register
    task automatic write_modes(logic [15:0] m);
        valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.modes = m;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [15:0] phase_modes [6];
        sb = new();
        samples_sent = 0;
        drain_stall = 0;
        for (int c = 0; c < NCH; c++) chan_time[c] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        valid = 1'b0;
        channel = '0;
        sample_value = '0;
        source_id = '0;
        time_us = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: mode none on reset, then rate/average on even/odd channels
        send_sample(3'd0, 32'd5, 8'd0, 48'd10);
        write_modes({4{MODE_AVG, MODE_RATE}});
        send_sample(3'd1, 32'h7fffffff, 8'hff, 48'hffffffffffff);
        send_sample(3'd1, 32'h7fffffff, 8'h00, 48'd0);
        send_sample(3'd2, 32'h80000000, 8'h5a, 48'd100);
        send_sample(3'd2, 32'h7fffffff, 8'ha5, 48'd101);
        send_sample(3'd2, 32'h80000000, 8'h01, 48'd102);
        send_sample(3'd2, 32'h0, 8'h02, 48'd102);
        send_sample(3'd2, 32'd50, 8'h03, 48'd90);
        send_sample(3'd0, 32'd7, 8'h04, 48'd10);
        send_sample(3'd0, 32'd8, 8'h05, 48'hffffffffffff);
        send_sample(3'd0, 32'h80000000, 8'h06, 48'd0);
        for (int i = 0; i < 18; i++)
            send_sample(3'd7, (i % 2) ? 32'h80000000 : 32'h80000001, 8'(i), 48'(i));
        write_modes(16'hffff);
        send_sample(3'd3, 32'd1, 8'd9, 48'd5);

        // random phases over several mode settings, extremes included
        phase_modes = '{16'h0000, 16'h5555, 16'haaaa, 16'hffff, 16'h0000, 16'h0000};
        for (int p = 0; p < 6; p++)
        begin
            write_modes(p >= 4 ? 16'($urandom) : phase_modes[p]);
            drain_stall = (p == 2);
            for (int i = 0; i < 180; i++)
                send_next(3'($urandom_range(0, 7)), rand_value());
        end
        drain_stall = 0;
        valid <= 1'b0;

        // drain
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("covered %0d sample beats and %0d result beats", samples_sent,
                 sb.results_seen);
        $display("modes swept: none, rate, average, reserved and mixed settings");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
